>>> hw/rtl/pmr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_pkg: shared types and constants for plane mean removal
// Widths, store depth and the transaction payload structs.
// ----------------------------------------------------------------------------
package pmr_pkg;

    localparam int MAX_POINTS = 4096;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int COUNT_W    = 13;
    localparam int IDX_W      = 12;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 44;
    localparam int STEP_W     = $clog2(SUM_W + 1);

    localparam logic [COUNT_W-1:0] POINTS_RESET = COUNT_W'(4096);
    localparam logic [COUNT_W-1:0] POINTS_MAX   = COUNT_W'(MAX_POINTS);

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_FLUSH  = 1'b1;

    typedef struct packed {
        logic                     mode;
        logic signed [DATA_W-1:0] sample;
    } pmr_in_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] corrected;
        logic        [IDX_W-1:0]  point_index;
        logic signed [DATA_W-1:0] plane_mean;
        logic                     last;
    } pmr_out_t;

endpackage

>>> hw/rtl/pmr_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_store: plane sample store
// Single-clock RAM, one write and one read port, registered read data.
// Read returns the old contents when both ports hit the same entry.
// ----------------------------------------------------------------------------
module pmr_store (
    input  logic                              aclk,
    input  logic                              we,
    input  logic [pmr_pkg::ADDR_W-1:0]        waddr,
    input  logic signed [pmr_pkg::DATA_W-1:0] wdata,
    input  logic                              re,
    input  logic [pmr_pkg::ADDR_W-1:0]        raddr,
    output logic signed [pmr_pkg::DATA_W-1:0] rdata
);

    logic signed [pmr_pkg::DATA_W-1:0] store_mem [pmr_pkg::MAX_POINTS];
    logic signed [pmr_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            store_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= store_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/pmr_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmr_divider: plane sum divided by point count
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// done stays high from completion until the next start.
// ----------------------------------------------------------------------------
module pmr_divider (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [pmr_pkg::SUM_W-1:0]   dividend,
    input  logic [pmr_pkg::COUNT_W-1:0]        divisor,
    output logic                               done,
    output logic signed [pmr_pkg::DATA_W-1:0]  quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [pmr_pkg::SUM_W-1:0]     work_reg;
    logic [pmr_pkg::COUNT_W-1:0]   rem_reg;
    logic [pmr_pkg::COUNT_W-1:0]   div_reg;
    logic [pmr_pkg::STEP_W-1:0]    step_reg;

    logic [pmr_pkg::SUM_W-1:0]     magnitude;
    logic [pmr_pkg::COUNT_W:0]     rem_shift;
    logic                          fits;
    logic [pmr_pkg::COUNT_W:0]     rem_step;
    logic [pmr_pkg::SUM_W-1:0]     quot_full;

    always_comb begin
        magnitude = dividend[pmr_pkg::SUM_W-1] ? (~dividend + 1'b1) : dividend;
        rem_shift = {rem_reg, work_reg[pmr_pkg::SUM_W-1]};
        fits      = rem_shift >= {1'b0, div_reg};
        rem_step  = fits ? (rem_shift - {1'b0, div_reg}) : rem_shift;
        quot_full = neg_reg ? (~work_reg + 1'b1) : work_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            neg_reg  <= dividend[pmr_pkg::SUM_W-1];
            work_reg <= magnitude;
            rem_reg  <= '0;
            div_reg  <= divisor;
            step_reg <= '0;
        end else if (busy_reg) begin
            work_reg <= {work_reg[pmr_pkg::SUM_W-2:0], fits};
            // remainder stays below the divisor, so its low bits hold it fully
            rem_reg  <= rem_step[pmr_pkg::COUNT_W-1:0];
            step_reg <= step_reg + 1'b1;
            if (step_reg == pmr_pkg::STEP_W'(pmr_pkg::SUM_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_full[pmr_pkg::DATA_W-1:0];

endmodule

>>> hw/rtl/plane_mean_removal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plane_mean_removal_unit: per-plane mean subtraction
// Loads one plane into a store while emitting the previous plane minus its
// mean, saturated to 32 bits.
// ----------------------------------------------------------------------------
// For each transaction the store is read and written in the accept cycle,
// and the result is formed from the registered read data in the next. The
// sample that completes a plane holds the input until the new mean is taken:
// the one-bit-per-cycle divider runs its 44 steps from the accept edge, and
// the mean is registered from its quotient once it reports done. Output
// backpressure holds the block in its result cycle. The store needs no
// clearing after reset; the user must write plane_points through
// cfg_valid/cfg_data while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module plane_mean_removal_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pmr_pkg::COUNT_W-1:0]   cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pmr_pkg::pmr_in_t              s_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output pmr_pkg::pmr_out_t             m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESULT,
        ST_DIV
    } state_t;

    state_t                              state_reg;
    logic [pmr_pkg::COUNT_W-1:0]         points_reg;
    logic [pmr_pkg::IDX_W-1:0]           fill_reg;
    logic signed [pmr_pkg::SUM_W-1:0]    sum_reg;
    logic signed [pmr_pkg::DATA_W-1:0]   mean_reg;
    logic                                pending_reg;
    logic [pmr_pkg::IDX_W-1:0]           drain_reg;
    logic                                emit_reg;
    logic                                div_wait_reg;
    logic [pmr_pkg::IDX_W-1:0]           idx_reg;
    logic                                last_reg;
    logic signed [pmr_pkg::DATA_W-1:0]   out_mean_reg;
    logic                                m_valid_reg;
    pmr_pkg::pmr_out_t                   m_data_reg;

    logic [pmr_pkg::COUNT_W-1:0]         count;
    logic                                accept;
    logic                                result_load;
    logic                                emit_next;
    logic                                last_next;
    logic                                pending_next;
    logic [pmr_pkg::IDX_W-1:0]           drain_next;
    logic [pmr_pkg::IDX_W-1:0]           fill_next;
    logic signed [pmr_pkg::SUM_W-1:0]    sum_next;
    logic signed [pmr_pkg::SUM_W-1:0]    sum_add;
    logic                                div_start;
    logic [pmr_pkg::COUNT_W-1:0]         drain_inc;
    logic [pmr_pkg::COUNT_W-1:0]         fill_inc;

    logic signed [pmr_pkg::DATA_W-1:0]   store_rdata;
    logic                                div_done;
    logic signed [pmr_pkg::DATA_W-1:0]   div_quot;
    logic signed [pmr_pkg::DATA_W:0]     diff;
    logic signed [pmr_pkg::DATA_W-1:0]   corrected;

    assign cfg_ready   = 1'b1;
    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign result_load = (state_reg == ST_RESULT) && emit_reg && (!m_valid_reg || m_ready);

    always_comb begin
        if (points_reg == '0) begin
            count = pmr_pkg::COUNT_W'(1);
        end else if (points_reg > pmr_pkg::POINTS_MAX) begin
            count = pmr_pkg::POINTS_MAX;
        end else begin
            count = points_reg;
        end
    end

    // drain one pending point, then place the new sample
    always_comb begin
        emit_next    = 1'b0;
        last_next    = 1'b0;
        pending_next = pending_reg;
        drain_next   = drain_reg;
        drain_inc    = {1'b0, drain_reg} + 1'b1;
        fill_inc     = {1'b0, fill_reg} + 1'b1;
        sum_add      = sum_reg + pmr_pkg::SUM_W'(s_data.sample);
        div_start    = 1'b0;
        if (pending_reg) begin
            if ({1'b0, drain_reg} >= count) begin
                pending_next = 1'b0;
                drain_next   = '0;
            end else begin
                emit_next = 1'b1;
                last_next = (drain_inc == count);
                if (drain_inc >= count) begin
                    pending_next = 1'b0;
                    drain_next   = '0;
                end else begin
                    drain_next = drain_inc[pmr_pkg::IDX_W-1:0];
                end
            end
        end
        if (s_data.mode == pmr_pkg::MODE_FLUSH) begin
            fill_next = '0;
            sum_next  = '0;
        end else if (fill_inc >= count) begin
            fill_next    = '0;
            sum_next     = '0;
            pending_next = 1'b1;
            drain_next   = '0;
            div_start    = 1'b1;
        end else begin
            fill_next = fill_inc[pmr_pkg::IDX_W-1:0];
            sum_next  = sum_add;
        end
    end

    always_comb begin
        diff = {store_rdata[pmr_pkg::DATA_W-1], store_rdata}
             - {out_mean_reg[pmr_pkg::DATA_W-1], out_mean_reg};
        if (diff[pmr_pkg::DATA_W] != diff[pmr_pkg::DATA_W-1]) begin
            corrected = diff[pmr_pkg::DATA_W]
                      ? {1'b1, {(pmr_pkg::DATA_W-1){1'b0}}}
                      : {1'b0, {(pmr_pkg::DATA_W-1){1'b1}}};
        end else begin
            corrected = diff[pmr_pkg::DATA_W-1:0];
        end
    end

    pmr_store u_store (
        .aclk  (aclk),
        .we    (accept && (s_data.mode == pmr_pkg::MODE_SAMPLE)),
        .waddr (pmr_pkg::ADDR_W'(fill_reg)),
        .wdata (s_data.sample),
        .re    (accept),
        .raddr (pmr_pkg::ADDR_W'(drain_reg)),
        .rdata (store_rdata)
    );

    pmr_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept && div_start),
        .dividend (sum_add),
        .divisor  (count),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            points_reg   <= pmr_pkg::POINTS_RESET;
            fill_reg     <= '0;
            sum_reg      <= '0;
            mean_reg     <= '0;
            pending_reg  <= 1'b0;
            drain_reg    <= '0;
            emit_reg     <= 1'b0;
            div_wait_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                points_reg <= cfg_data;
            end
            if (result_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        fill_reg     <= fill_next;
                        sum_reg      <= sum_next;
                        pending_reg  <= pending_next;
                        drain_reg    <= drain_next;
                        emit_reg     <= emit_next;
                        div_wait_reg <= div_start;
                        idx_reg      <= drain_reg;
                        last_reg     <= last_next;
                        out_mean_reg <= mean_reg;
                        state_reg    <= ST_RESULT;
                    end
                end
                ST_RESULT: begin
                    if (!emit_reg || !m_valid_reg || m_ready) begin
                        if (emit_reg) begin
                            m_data_reg.corrected   <= corrected;
                            m_data_reg.point_index <= idx_reg;
                            m_data_reg.plane_mean  <= out_mean_reg;
                            m_data_reg.last        <= last_reg;
                        end
                        state_reg <= div_wait_reg ? ST_DIV : ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        mean_reg  <= div_quot;
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
